// ===== src/vwe_pkg.sv =====
package vwe_pkg;

  localparam int COORD_W = 24;
  localparam int DIR_W   = 16;
  localparam int D2_W    = 61;

  localparam logic [2:0] OP_CLEAR       = 3'd0;
  localparam logic [2:0] OP_ADD_POINT   = 3'd1;
  localparam logic [2:0] OP_ADD_EDGE    = 3'd2;
  localparam logic [2:0] OP_PICK_VERTEX = 3'd3;
  localparam logic [2:0] OP_PICK_EDGE   = 3'd4;

  localparam logic [1:0] ST_NEW     = 2'd0;
  localparam logic [1:0] ST_MATCHED = 2'd1;
  localparam logic [1:0] ST_NO_HIT  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [1:0] CFG_WELD_TOL    = 2'd0;
  localparam logic [1:0] CFG_PICK_RADIUS = 2'd1;

  localparam logic [7:0] NO_FACE = 8'hFF;

  typedef struct packed {
    logic [7:0] face_b;
    logic [7:0] face_a;
    logic [7:0] end_pt;
    logic [7:0] start_pt;
  } edge_t;

  typedef struct packed {
    logic                        start;
    logic [2:0][COORD_W-1:0]     p;
    logic [2:0][COORD_W-1:0]     o;
    logic [2:0][DIR_W-1:0]       d;
  } perp_req_t;

  typedef struct packed {
    logic            done;
    logic [D2_W-1:0] d2;
  } perp_rsp_t;

endpackage

// ===== src/vertex_weld_edge_pair_pick_table_core.sv =====
// Welded point table and edge table with ray picking. One transaction in gives one result out.
// Points live in a single-port-read RAM of POINT_DEPTH entries, edges in one of EDGE_DEPTH
// entries, both with a registered read; every add and pick walks its table one entry at
// a time. Clear and unknown ops go straight to the result. Add point and add edge read, then
// compare, each stored entry in turn; pick vertex and pick edge are set by the shared distance
// unit, which runs nine products through one multiplier, each in a multiply and an accumulate
// state, plus the point reads of each entry. No clearing pass is needed after reset. A new
// transaction is taken while the previous result still waits at the output register.
module vertex_weld_edge_pair_pick_table_core import vwe_pkg::*; #(
  parameter int POINT_DEPTH = 256,
  parameter int EDGE_DEPTH  = 512
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, start_point, end_point, face_id
  input  logic [143:0] in_tdata,
  // op
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // index, edge_start, edge_end, edge_face_a, edge_face_b, zero fill
  output logic [47:0]  out_tdata,
  // status
  output logic [1:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata
);

  localparam int PIW = $clog2(POINT_DEPTH);
  localparam int EIW = $clog2(EDGE_DEPTH);
  localparam int PCW = $clog2(POINT_DEPTH + 1);
  localparam int ECW = $clog2(EDGE_DEPTH + 1);
  localparam int SW  = (PCW > ECW) ? PCW : ECW;

  typedef enum logic [3:0] {
    S_IDLE, S_PT_RD, S_PT_CHK, S_ED_RD, S_ED_CHK, S_PK_RD, S_PK_PT,
    S_PK_EDGE, S_PK_A, S_PK_B, S_PK_WAIT, S_DONE
  } state_t;

  state_t                   state_r;
  logic [15:0]              weld_tol_r;
  logic [15:0]              pick_rad_r;
  logic [PCW-1:0]           p_count_r;
  logic [ECW-1:0]           e_count_r;
  logic [SW-1:0]            i_r;

  logic [2:0]               op_r;
  logic [2:0][COORD_W-1:0]  pos_r;
  logic [2:0][DIR_W-1:0]    dir_r;
  logic [7:0]               sp_r;
  logic [7:0]               ep_r;
  logic [7:0]               face_r;

  logic [31:0]              best_r;
  logic                     hit_r;
  logic [SW-1:0]            best_i_r;
  edge_t                    best_edge_r;
  edge_t                    cur_edge_r;
  logic [2:0][COORD_W-1:0]  a_r;
  logic                     a_oob_r;

  logic [8:0]               res_index_r;
  logic [1:0]               res_status_r;
  edge_t                    res_edge_r;

  logic                     out_valid_r;
  logic [8:0]               out_index_r;
  logic [1:0]               out_status_r;
  edge_t                    out_edge_r;

  logic                     p_we;
  logic [PIW-1:0]           p_waddr;
  logic [PIW-1:0]           p_raddr;
  logic [2:0][COORD_W-1:0]  p_rdata;
  logic                     e_we;
  logic [EIW-1:0]           e_waddr;
  edge_t                    e_wdata;
  edge_t                    e_rdata;

  perp_req_t                perp_req;
  perp_rsp_t                perp_rsp;

  logic                     pt_match;
  logic                     ed_match;
  logic                     b_oob;
  logic [2:0][COORD_W-1:0]  b_pt;
  logic [2:0][COORD_W-1:0]  mid;
  logic [SW-1:0]            lim;
  logic                     p_more;
  logic                     e_more;
  logic                     k_more;
  logic [24:0]              diff;
  logic [24:0]              dmag;
  logic [24:0]              msum;

  vwe_ram #(.WIDTH(3 * COORD_W), .DEPTH(POINT_DEPTH)) u_point_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (pos_r),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  vwe_ram #(.WIDTH(32), .DEPTH(EDGE_DEPTH)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (i_r[EIW-1:0]),
    .rdata (e_rdata)
  );

  vwe_perp u_perp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (perp_req),
    .rsp   (perp_rsp)
  );

  always_comb begin
    p_more = i_r < SW'(p_count_r);
    e_more = i_r < SW'(e_count_r);
    lim    = (op_r == OP_PICK_VERTEX) ? SW'(p_count_r) : SW'(e_count_r);
    k_more = i_r < lim;

    pt_match = 1'b1;
    diff     = '0;
    dmag     = '0;
    for (int k = 0; k < 3; k++) begin
      diff = 25'(signed'(pos_r[k])) - 25'(signed'(p_rdata[k]));
      dmag = diff[24] ? (25'd0 - diff) : diff;
      if (dmag > 25'(weld_tol_r)) begin
        pt_match = 1'b0;
      end
    end

    ed_match = (e_rdata.start_pt == ep_r) && (e_rdata.end_pt == sp_r);

    // points beyond the table read as the origin
    b_oob = {24'd0, cur_edge_r.end_pt} >= 32'(POINT_DEPTH);
    b_pt  = b_oob ? '0 : p_rdata;
    msum  = '0;
    for (int k = 0; k < 3; k++) begin
      msum   = 25'(signed'(a_r[k])) + 25'(signed'(b_pt[k]));
      mid[k] = msum[24:1];
    end

    case (state_r)
      S_PK_EDGE: p_raddr = PIW'(e_rdata.start_pt);
      S_PK_A:    p_raddr = PIW'(cur_edge_r.end_pt);
      default:   p_raddr = i_r[PIW-1:0];
    endcase

    p_we    = (state_r == S_PT_RD) && !p_more && (p_count_r < PCW'(POINT_DEPTH));
    p_waddr = p_count_r[PIW-1:0];

    e_we    = 1'b0;
    e_waddr = i_r[EIW-1:0];
    e_wdata = e_rdata;
    if (state_r == S_ED_CHK && ed_match) begin
      e_we           = 1'b1;
      e_wdata.face_b = face_r;
    end else if (state_r == S_ED_RD && !e_more && e_count_r < ECW'(EDGE_DEPTH)) begin
      e_we    = 1'b1;
      e_waddr = e_count_r[EIW-1:0];
      e_wdata = '{face_b: NO_FACE, face_a: face_r, end_pt: ep_r, start_pt: sp_r};
    end

    perp_req.start = (state_r == S_PK_PT) || (state_r == S_PK_B);
    perp_req.p     = (op_r == OP_PICK_VERTEX) ? p_rdata : mid;
    perp_req.o     = pos_r;
    perp_req.d     = dir_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      weld_tol_r  <= 16'd26;
      pick_rad_r  <= 16'd2048;
      p_count_r   <= '0;
      e_count_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_WELD_TOL:    weld_tol_r <= cfg_wdata;
          CFG_PICK_RADIUS: pick_rad_r <= cfg_wdata;
          default: ;
        endcase
      end
      // in S_DONE the output register is reloaded instead
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r        <= in_tuser;
            pos_r       <= in_tdata[71:0];
            dir_r       <= in_tdata[119:72];
            sp_r        <= in_tdata[127:120];
            ep_r        <= in_tdata[135:128];
            face_r      <= in_tdata[143:136];
            i_r         <= '0;
            best_r      <= 32'(pick_rad_r) * 32'(pick_rad_r);
            hit_r       <= 1'b0;
            best_i_r    <= '0;
            best_edge_r <= '0;
            res_index_r <= '0;
            res_edge_r  <= '0;
            res_status_r <= ST_NO_HIT;
            case (in_tuser)
              OP_CLEAR: begin
                p_count_r    <= '0;
                e_count_r    <= '0;
                res_status_r <= ST_NEW;
                state_r      <= S_DONE;
              end
              OP_ADD_POINT:   state_r <= S_PT_RD;
              OP_ADD_EDGE:    state_r <= S_ED_RD;
              OP_PICK_VERTEX: state_r <= S_PK_RD;
              OP_PICK_EDGE:   state_r <= S_PK_RD;
              default:        state_r <= S_DONE;
            endcase
          end
        end
        S_PT_RD: begin
          if (p_more) begin
            state_r <= S_PT_CHK;
          end else begin
            if (p_count_r < PCW'(POINT_DEPTH)) begin
              res_index_r  <= 9'(p_count_r);
              res_status_r <= ST_NEW;
              p_count_r    <= p_count_r + 1'b1;
            end else begin
              res_status_r <= ST_FULL;
            end
            state_r <= S_DONE;
          end
        end
        S_PT_CHK: begin
          if (pt_match) begin
            res_index_r  <= 9'(i_r);
            res_status_r <= ST_MATCHED;
            state_r      <= S_DONE;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_PT_RD;
          end
        end
        S_ED_RD: begin
          if (e_more) begin
            state_r <= S_ED_CHK;
          end else begin
            if (e_count_r < ECW'(EDGE_DEPTH)) begin
              res_index_r  <= 9'(e_count_r);
              res_status_r <= ST_NEW;
              res_edge_r   <= e_wdata;
              e_count_r    <= e_count_r + 1'b1;
            end else begin
              res_status_r <= ST_FULL;
            end
            state_r <= S_DONE;
          end
        end
        S_ED_CHK: begin
          if (ed_match) begin
            res_index_r  <= 9'(i_r);
            res_status_r <= ST_MATCHED;
            res_edge_r   <= e_wdata;
            state_r      <= S_DONE;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_ED_RD;
          end
        end
        S_PK_RD: begin
          if (k_more) begin
            state_r <= (op_r == OP_PICK_VERTEX) ? S_PK_PT : S_PK_EDGE;
          end else begin
            if (hit_r) begin
              res_index_r  <= 9'(best_i_r);
              res_status_r <= ST_NEW;
              if (op_r == OP_PICK_EDGE) begin
                res_edge_r <= best_edge_r;
              end
            end
            state_r <= S_DONE;
          end
        end
        S_PK_PT: state_r <= S_PK_WAIT;
        S_PK_EDGE: begin
          cur_edge_r <= e_rdata;
          a_oob_r    <= {24'd0, e_rdata.start_pt} >= 32'(POINT_DEPTH);
          state_r    <= S_PK_A;
        end
        S_PK_A: begin
          a_r     <= a_oob_r ? '0 : p_rdata;
          state_r <= S_PK_B;
        end
        S_PK_B: state_r <= S_PK_WAIT;
        S_PK_WAIT: begin
          if (perp_rsp.done) begin
            // strict compare keeps the first of equal distances
            if (perp_rsp.d2 < {29'd0, best_r}) begin
              best_r      <= perp_rsp.d2[31:0];
              best_i_r    <= i_r;
              hit_r       <= 1'b1;
              best_edge_r <= cur_edge_r;
            end
            i_r     <= i_r + 1'b1;
            state_r <= S_PK_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_index_r  <= res_index_r;
            out_status_r <= res_status_r;
            out_edge_r   <= res_edge_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_edge_r, out_index_r};
  assign out_tuser  = out_status_r;

  a_point_count: assert property (@(posedge clk) disable iff (!rst_n)
    p_count_r <= PCW'(POINT_DEPTH))
    else $error("point count beyond table depth");

  a_edge_count: assert property (@(posedge clk) disable iff (!rst_n)
    e_count_r <= ECW'(EDGE_DEPTH))
    else $error("edge count beyond table depth");

  a_perp_done: assert property (@(posedge clk) disable iff (!rst_n)
    perp_rsp.done |-> state_r == S_PK_WAIT)
    else $error("distance result arrived outside a pick scan");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid_r || out_tready)) |=> out_valid_r)
    else $error("finished result not loaded into output register");

endmodule

// ===== src/vwe_ram.sv =====
module vwe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/vwe_perp.sv =====
module vwe_perp import vwe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  perp_req_t req,
  output perp_rsp_t rsp
);

  typedef enum logic [1:0] {P_IDLE, P_MUL, P_ACC} pstate_t;

  pstate_t                  state_r;
  logic [3:0]               step_r;
  logic signed [24:0]       v_r [3];
  logic signed [DIR_W-1:0]  d_r [3];
  logic signed [59:0]       prod_r;
  logic signed [42:0]       dot_r;
  logic signed [29:0]       t_r;
  logic signed [29:0]       e_r [3];
  logic [D2_W-1:0]          sum_r;
  logic                     done_r;

  logic [1:0]               lane;
  logic [1:0]               grp;
  logic signed [29:0]       mul_a;
  logic signed [29:0]       mul_b;
  logic signed [43:0]       tsum;
  logic signed [45:0]       rsum;
  logic signed [31:0]       rnd;

  // nine products per entry: three for the dot, three for t*d, three squares
  always_comb begin
    if (step_r < 4'd3) begin
      grp  = 2'd0;
      lane = step_r[1:0];
    end else if (step_r < 4'd6) begin
      grp  = 2'd1;
      lane = 2'(step_r - 4'd3);
    end else begin
      grp  = 2'd2;
      lane = 2'(step_r - 4'd6);
    end
    mul_b = 30'(d_r[lane]);
    case (grp)
      2'd0:    mul_a = 30'(v_r[lane]);
      2'd1:    mul_a = t_r;
      default: begin
        mul_a = e_r[lane];
        mul_b = e_r[lane];
      end
    endcase
    tsum = 44'(dot_r) + 44'(signed'(prod_r[42:0])) + 44'sd8192;
    rsum = signed'(prod_r[45:0]) + 46'sd8192;
    rnd  = rsum[45:14];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_IDLE;
      done_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        P_IDLE: begin
          if (req.start) begin
            for (int k = 0; k < 3; k++) begin
              v_r[k] <= 25'(signed'(req.p[k])) - 25'(signed'(req.o[k]));
              d_r[k] <= signed'(req.d[k]);
            end
            dot_r   <= '0;
            sum_r   <= '0;
            step_r  <= '0;
            state_r <= P_MUL;
          end
        end
        P_MUL: begin
          prod_r  <= mul_a * mul_b;
          state_r <= P_ACC;
        end
        P_ACC: begin
          case (grp)
            2'd0: begin
              dot_r <= dot_r + signed'(prod_r[42:0]);
              if (lane == 2'd2) begin
                t_r <= tsum[43:14];
              end
            end
            2'd1: e_r[lane] <= 30'(32'(v_r[lane]) - rnd);
            default: sum_r <= sum_r + {1'b0, prod_r};
          endcase
          if (step_r == 4'd8) begin
            done_r  <= 1'b1;
            state_r <= P_IDLE;
          end else begin
            step_r  <= step_r + 4'd1;
            state_r <= P_MUL;
          end
        end
        default: state_r <= P_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.d2   = sum_r;

endmodule

// ===== sim/vwe_checker.sv =====
module vwe_checker import vwe_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [143:0] in_tdata,
  input  logic [2:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [47:0]  out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata,
  output int           errors,
  output int           pending,
  output int           hits
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS  = 256;
  localparam int NEDGE = 512;

  typedef struct {
    logic [8:0] index;
    logic [1:0] status;
    edge_t      ed;
  } table_result_t;

  longint        pt_coord[NPTS][3];
  edge_t         edge_tab[NEDGE];
  int unsigned   pt_count;
  int unsigned   edge_count;
  logic [15:0]   weld_tol;
  logic [15:0]   radius;
  table_result_t result_q[$];

  assign pending = result_q.size();

  function automatic longint round14(longint x);
    return (x + 8192) >>> 14;
  endfunction

  function automatic longint ray_dist_sq(input longint p[3], input longint o[3],
                                         input longint d[3]);
    longint v[3];
    longint dot;
    longint t;
    longint e;
    longint sum;
    dot = 0;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      v[k] = p[k] - o[k];
      dot += v[k] * d[k];
    end
    t = round14(dot);
    for (int k = 0; k < 3; k++) begin
      e = v[k] - round14(t * d[k]);
      sum += e * e;
    end
    return sum;
  endfunction

  function automatic table_result_t run_op(input logic [143:0] data, input logic [2:0] op);
    table_result_t r;
    longint pos[3];
    longint dir[3];
    longint p[3];
    longint best;
    longint d2;
    logic [7:0] sp;
    logic [7:0] ep;
    logic [7:0] face;
    bit found;
    int unsigned lim;
    r.index = '0;
    r.status = ST_NO_HIT;
    r.ed = '0;
    for (int k = 0; k < 3; k++) begin
      pos[k] = longint'($signed(data[k*24 +: 24]));
      dir[k] = longint'($signed(data[72 + k*16 +: 16]));
    end
    sp = data[127:120];
    ep = data[135:128];
    face = data[143:136];
    found = 0;
    case (op)
      OP_CLEAR: begin
        pt_count = 0;
        edge_count = 0;
        r.status = ST_NEW;
      end
      OP_ADD_POINT: begin
        for (int i = 0; i < pt_count && !found; i++) begin
          bit ok;
          ok = 1;
          for (int k = 0; k < 3; k++) begin
            d2 = pos[k] - pt_coord[i][k];
            if (d2 < 0) d2 = -d2;
            if (d2 > longint'(weld_tol)) ok = 0;
          end
          if (ok) begin
            found = 1;
            r.index = 9'(i);
            r.status = ST_MATCHED;
          end
        end
        if (!found) begin
          if (pt_count >= NPTS) begin
            r.status = ST_FULL;
          end else begin
            for (int k = 0; k < 3; k++) pt_coord[pt_count][k] = pos[k];
            r.index = 9'(pt_count);
            r.status = ST_NEW;
            pt_count++;
          end
        end
      end
      OP_ADD_EDGE: begin
        for (int i = 0; i < edge_count && !found; i++) begin
          if (edge_tab[i].start_pt == ep && edge_tab[i].end_pt == sp) begin
            found = 1;
            edge_tab[i].face_b = face;
            r.ed = edge_tab[i];
            r.index = 9'(i);
            r.status = ST_MATCHED;
          end
        end
        if (!found) begin
          if (edge_count >= NEDGE) begin
            r.status = ST_FULL;
          end else begin
            edge_tab[edge_count] = '{face_b: NO_FACE, face_a: face, end_pt: ep, start_pt: sp};
            r.ed = edge_tab[edge_count];
            r.index = 9'(edge_count);
            r.status = ST_NEW;
            edge_count++;
          end
        end
      end
      OP_PICK_VERTEX, OP_PICK_EDGE: begin
        best = longint'(radius) * longint'(radius);
        lim = (op == OP_PICK_VERTEX) ? pt_count : edge_count;
        for (int i = 0; i < lim; i++) begin
          for (int k = 0; k < 3; k++) begin
            if (op == OP_PICK_VERTEX) begin
              p[k] = pt_coord[i][k];
            end else begin
              p[k] = (pt_coord[edge_tab[i].start_pt][k] + pt_coord[edge_tab[i].end_pt][k]) >>> 1;
            end
          end
          d2 = ray_dist_sq(p, pos, dir);
          if (d2 < best) begin
            best = d2;
            r.index = 9'(i);
            found = 1;
          end
        end
        if (found) begin
          r.status = ST_NEW;
          if (op == OP_PICK_EDGE) r.ed = edge_tab[r.index];
          hits++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    table_result_t want;
    logic [7:0] got_f[6];
    logic [7:0] want_f[6];
    if (!rst_n) begin
      pt_count = 0;
      edge_count = 0;
      weld_tol = 16'd26;
      radius = 16'd2048;
      result_q.delete();
      errors = 0;
      hits = 0;
      for (int i = 0; i < NPTS; i++) for (int k = 0; k < 3; k++) pt_coord[i][k] = 0;
      for (int i = 0; i < NEDGE; i++) edge_tab[i] = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result, tdata %h tuser %0d", $time, out_tdata, out_tuser);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (out_tdata[8:0] != want.index) begin
            $display("%0t: index expected %0d actual %0d", $time, want.index, out_tdata[8:0]);
            errors++;
          end
          if (out_tuser != want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_tuser);
            errors++;
          end
          want_f = '{want.ed.start_pt, want.ed.end_pt, want.ed.face_a, want.ed.face_b, 0, 0};
          got_f = '{out_tdata[16:9], out_tdata[24:17], out_tdata[32:25], out_tdata[40:33],
                    0, 0};
          for (int k = 0; k < 4; k++) begin
            if (got_f[k] != want_f[k]) begin
              $display("%0t: edge field %0d expected %0d actual %0d",
                       $time, k, want_f[k], got_f[k]);
              errors++;
            end
          end
        end
      end
      if (in_tvalid && in_tready) result_q.push_back(run_op(in_tdata, in_tuser));
      if (cfg_we) begin
        if (cfg_addr == CFG_WELD_TOL) weld_tol = cfg_wdata;
        else if (cfg_addr == CFG_PICK_RADIUS) radius = cfg_wdata;
      end
    end
  end

endmodule

// ===== sim/tb_vertex_weld_edge_pair_pick_table_core.sv =====
module tb_vertex_weld_edge_pair_pick_table_core import vwe_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 40000000;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [47:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_we = 0;
  logic [1:0]   cfg_addr = '0;
  logic [15:0]  cfg_wdata = '0;
  int           errors;
  int           pending;
  int           hits;
  longint       cycles = 0;
  bit           no_idle = 0;
  int           stall = 0;
  int           sent = 0;

  always #4 clk = ~clk;

  vertex_weld_edge_pair_pick_table_core dut (.*);

  vwe_checker chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("tb_vertex_weld_edge_pair_pick_table_core: done, errors");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (stall > 0) begin
      stall--;
      out_tready = 0;
    end else begin
      out_tready = 1;
      if (!no_idle && $urandom_range(0, 99) < 15)
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
    end
  end

  task automatic send(input logic [2:0] op, input logic [23:0] x, input logic [23:0] y,
                      input logic [23:0] z, input logic [15:0] dx, input logic [15:0] dy,
                      input logic [15:0] dz, input logic [7:0] sp, input logic [7:0] ep,
                      input logic [7:0] face);
    int gap;
    gap = 0;
    if (!no_idle) begin
      gap = $urandom_range(0, 99);
      gap = (gap < 60) ? 0 : (gap < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    end
    repeat (gap) begin
      in_tvalid = 0;
      @(negedge clk);
    end
    in_tdata = {face, ep, sp, dz, dy, dx, z, y, x};
    in_tuser = op;
    in_tvalid = 1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 0;
    sent++;
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [15:0] value);
    cfg_we = 1;
    cfg_addr = addr;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [23:0] rand_coord();
    if ($urandom_range(0, 9) == 0) return 24'($urandom);
    return 24'(($urandom_range(0, 7) - 4) * 1024 + $urandom_range(0, 80) - 40);
  endfunction

  function automatic logic [47:0] rand_dir();
    logic [15:0] v[3];
    int ax;
    if ($urandom_range(0, 1)) begin
      v = '{16'd0, 16'd0, 16'd0};
      ax = $urandom_range(0, 2);
      v[ax] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
    end else begin
      for (int k = 0; k < 3; k++) v[k] = 16'($urandom_range(0, 32768) - 16384);
    end
    return {v[2], v[1], v[0]};
  endfunction

  function automatic logic [7:0] rand_pt();
    return ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
  endfunction

  task automatic random_op();
    int r;
    logic [2:0] op;
    logic [47:0] d;
    r = $urandom_range(0, 99);
    if (r < 9) op = OP_CLEAR;
    else if (r < 45) op = OP_ADD_POINT;
    else if (r < 68) op = OP_ADD_EDGE;
    else if (r < 82) op = OP_PICK_VERTEX;
    else if (r < 96) op = OP_PICK_EDGE;
    else op = 3'($urandom_range(5, 7));
    d = rand_dir();
    send(op, rand_coord(), rand_coord(), rand_coord(), d[15:0], d[31:16], d[47:32],
         rand_pt(), rand_pt(), 8'($urandom_range(0, 254)));
  endtask

  initial begin
    logic [15:0] tols[5];
    logic [15:0] radii[5];
    repeat (5) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // fill the point table with distinct points, extremes first, then overflow it
    write_reg(CFG_WELD_TOL, 16'd0);
    no_idle = 1;
    send(OP_ADD_POINT, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 0, 0, 0, 0, 0, 0);
    send(OP_ADD_POINT, 24'h800000, 24'h7FFFFF, 24'h800000, 0, 0, 0, 0, 0, 0);
    for (int i = 2; i < 257; i++)
      send(OP_ADD_POINT, 24'(i * 1000), 24'(-i * 997), 24'(i * 3), 0, 0, 0, 0, 0, 0);
    send(OP_ADD_POINT, 24'(5000), 24'(-5 * 997), 24'(15), 0, 0, 0, 0, 0, 0);
    // edge table: starts below 128 and ends at 128 or above, so no reverse ever exists
    for (int i = 0; i < 513; i++)
      send(OP_ADD_EDGE, 0, 0, 0, 0, 0, 0, 8'(i % 128), 8'(128 + i / 128), 8'(i % 255));
    no_idle = 0;
    send(OP_ADD_EDGE, 0, 0, 0, 0, 0, 0, 8'd128, 8'd3, 8'd254);
    send(OP_PICK_VERTEX, 24'(3000), 0, 0, 16'sd16384, 0, 0, 0, 0, 0);
    send(OP_PICK_VERTEX, 24'(8000), 24'(-8 * 997), 0, 0, 0, -16'sd16384, 0, 0, 0);
    send(OP_PICK_EDGE, 24'(2500), 0, 0, 0, -16'sd16384, 0, 0, 0, 0);
    for (int op = 5; op < 8; op++) send(3'(op), 0, 0, 0, 0, 0, 0, 0, 0, 0);
    drain();
    write_reg(CFG_PICK_RADIUS, 16'd0);
    send(OP_PICK_VERTEX, 24'(3000), 0, 0, 16'sd16384, 0, 0, 0, 0, 0);
    send(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(OP_PICK_EDGE, 0, 0, 0, 16'sd16384, 0, 0, 0, 0, 0);
    send(OP_ADD_POINT, 24'(7), 0, 0, 0, 0, 0, 0, 0, 0);

    tols = '{16'd26, 16'd0, 16'd65535, 16'd300, 16'($urandom)};
    radii = '{16'd2048, 16'd65535, 16'd0, 16'd512, 16'($urandom)};
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_reg(CFG_WELD_TOL, tols[ph]);
      write_reg(CFG_PICK_RADIUS, radii[ph]);
      for (int n = 0; n < 8; n++) begin
        if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        random_op();
      end
      no_idle = 0;
    end

    drain();
    repeat (200) @(negedge clk);
    $display("sent %0d transactions over full tables and 5 register settings, %0d pick hits",
             sent, hits);
    if (errors == 0) begin
      $display("tb_vertex_weld_edge_pair_pick_table_core: done, clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_vertex_weld_edge_pair_pick_table_core: done, errors");
    end
    $finish;
  end

endmodule
